### hw/rtl/bfcb_pkg.sv
package bfcb_pkg;

    localparam int TEMP_W     = 16;
    localparam int COORD_W    = 15;
    localparam int T_W        = 17;   // curve parameter, 0 .. 65536
    localparam int MID_W      = 16;   // a midpoint never reaches 65536
    localparam int SQ_W       = 33;   // u*u and t*t
    localparam int WGT_W      = 49;   // Bernstein weights, at most 2^48
    localparam int PROD_W     = 64;
    localparam int ACC_W      = 63;   // weighted sum stays below 2^63
    localparam int FRAC_SHIFT = 48;
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [T_W-1:0]   T_ONE   = 17'h1_0000;
    localparam logic [MID_W-1:0] MID_INIT = 16'h8000;

    // register indexes, in configuration order
    localparam logic [REG_IDX_W-1:0] REG_P0_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_P0_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_P1_X = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_P1_Y = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_P2_X = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_P2_Y = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_P3_X = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_P3_Y = 3'd7;

    localparam logic [COORD_W-1:0] REG_RESET [NUM_REGS] = '{
        15'd0, 15'd0, 15'd10240, 15'd15360, 15'd15360, 15'd10240, 15'd25600, 15'd25600
    };

    // multiplier operations, issued in this order for one curve evaluation
    typedef enum logic [3:0] {
        OP_UU, OP_TT, OP_U2U, OP_U2T, OP_T2U, OP_T2T,
        OP_W0X, OP_W0Y, OP_W1X, OP_W1Y, OP_W2X, OP_W2Y, OP_W3X, OP_W3Y,
        OP_NONE
    } t_mul_op;

    localparam t_mul_op OP_FIRST = OP_UU;
    localparam t_mul_op OP_LAST  = OP_W3Y;

    typedef enum logic [1:0] {
        S_IDLE, S_EVAL, S_DECIDE, S_FINISH
    } t_state;

    typedef struct packed {
        logic    start;     // load temperature, reset the search interval
        t_mul_op op;
        logic    decide;    // compare x and narrow the interval
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic x_eq;
        logic x_lt;
    } t_dp_status;

endpackage

### hw/rtl/bfcb_ctrl.sv
module bfcb_ctrl
    import bfcb_pkg::*;
#(
    parameter int T_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam int STEP_W = $clog2(T_BITS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(T_BITS - 1);

    t_state              r_state, n_state;
    t_mul_op             r_op, n_op;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid, n_out_valid;
    logic                out_free;
    logic                last_step;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign last_step = i_status.x_eq || (r_step == STEP_LAST);

    // next state
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                    n_op    = OP_FIRST;
                    n_step  = '0;
                end
            end
            S_EVAL: begin
                if (r_op == OP_LAST) begin
                    n_state = S_DECIDE;
                end else begin
                    n_op = t_mul_op'(4'(r_op) + 4'd1);
                end
            end
            S_DECIDE: begin
                if (last_step) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_EVAL;
                    n_op    = OP_FIRST;
                    n_step  = r_step + 1'b1;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = OP_NONE;
        o_in_stall     = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.start = i_in_valid;
            end
            S_EVAL:   o_cmd.op       = r_op;
            S_DECIDE: o_cmd.decide   = 1'b1;
            S_FINISH: o_cmd.load_out = out_free;
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_FIRST;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### hw/rtl/bfcb_datapath.sv
module bfcb_datapath
    import bfcb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_write,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [TEMP_W-1:0]     i_temperature,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output logic [COORD_W-1:0]    o_fan_speed
);

    logic [COORD_W-1:0] r_coord [NUM_REGS];
    logic [TEMP_W-1:0]  r_temp;
    logic [T_W-1:0]     r_lo, r_hi;
    logic [MID_W-1:0]   r_mid;
    logic [SQ_W-1:0]    r_u2, r_t2;
    logic [WGT_W-1:0]   r_w0, r_w1, r_w2, r_w3;
    logic [PROD_W-1:0]  r_prod;
    t_mul_op            r_wb_op;
    logic [ACC_W-1:0]   r_acc_x, r_acc_y;
    logic [COORD_W-1:0] r_fan_speed;

    logic [T_W-1:0]     t_val, u_val;
    logic [WGT_W-1:0]   op_a;
    logic [T_W-1:0]     op_b;
    logic [WGT_W+T_W-1:0] mul_full;
    logic [WGT_W-1:0]   prod_w, prod_w3;
    logic [ACC_W-1:0]   prod_acc;
    logic [COORD_W-1:0] x_val;
    logic [T_W-1:0]     n_lo, n_hi;
    logic [T_W:0]       mid_sum;

    assign t_val = {1'b0, r_mid};
    assign u_val = T_ONE - t_val;

    // operand select for the shared multiplier
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (i_cmd.op)
            OP_UU:  begin op_a = WGT_W'(u_val); op_b = u_val; end
            OP_TT:  begin op_a = WGT_W'(t_val); op_b = t_val; end
            OP_U2U: begin op_a = WGT_W'(r_u2);  op_b = u_val; end
            OP_U2T: begin op_a = WGT_W'(r_u2);  op_b = t_val; end
            OP_T2U: begin op_a = WGT_W'(r_t2);  op_b = u_val; end
            OP_T2T: begin op_a = WGT_W'(r_t2);  op_b = t_val; end
            OP_W0X: begin op_a = r_w0; op_b = T_W'(r_coord[REG_P0_X]); end
            OP_W0Y: begin op_a = r_w0; op_b = T_W'(r_coord[REG_P0_Y]); end
            OP_W1X: begin op_a = r_w1; op_b = T_W'(r_coord[REG_P1_X]); end
            OP_W1Y: begin op_a = r_w1; op_b = T_W'(r_coord[REG_P1_Y]); end
            OP_W2X: begin op_a = r_w2; op_b = T_W'(r_coord[REG_P2_X]); end
            OP_W2Y: begin op_a = r_w2; op_b = T_W'(r_coord[REG_P2_Y]); end
            OP_W3X: begin op_a = r_w3; op_b = T_W'(r_coord[REG_P3_X]); end
            OP_W3Y: begin op_a = r_w3; op_b = T_W'(r_coord[REG_P3_Y]); end
            default: ;
        endcase
    end

    assign mul_full = op_a * op_b;

    assign prod_w   = r_prod[WGT_W-1:0];
    assign prod_w3  = prod_w + {prod_w[WGT_W-2:0], 1'b0};   // the middle weights carry a 3
    assign prod_acc = r_prod[ACC_W-1:0];

    assign x_val          = r_acc_x[FRAC_SHIFT +: COORD_W];
    assign o_status.x_eq  = ({1'b0, x_val} == r_temp);
    assign o_status.x_lt  = ({1'b0, x_val} < r_temp);

    assign n_lo    = o_status.x_lt ? t_val : r_lo;
    assign n_hi    = o_status.x_lt ? r_hi : t_val;
    assign mid_sum = {1'b0, n_lo} + {1'b0, n_hi};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_op <= OP_NONE;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_coord[i] <= REG_RESET[i];
            end
        end else begin
            r_wb_op <= i_cmd.op;
            if (i_cfg_write && (i_cfg_index < CFG_IDX_W'(NUM_REGS))) begin
                r_coord[i_cfg_index[REG_IDX_W-1:0]] <= i_cfg_data[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_full[PROD_W-1:0];

        // write back the product issued in the previous cycle
        case (r_wb_op)
            OP_UU:  r_u2    <= r_prod[SQ_W-1:0];
            OP_TT:  r_t2    <= r_prod[SQ_W-1:0];
            OP_U2U: r_w0    <= prod_w;
            OP_U2T: r_w1    <= prod_w3;
            OP_T2U: r_w2    <= prod_w3;
            OP_T2T: r_w3    <= prod_w;
            OP_W0X: r_acc_x <= prod_acc;
            OP_W0Y: r_acc_y <= prod_acc;
            OP_W1X, OP_W2X, OP_W3X: r_acc_x <= r_acc_x + prod_acc;
            OP_W1Y, OP_W2Y, OP_W3Y: r_acc_y <= r_acc_y + prod_acc;
            default: ;
        endcase

        if (i_cmd.start) begin
            r_temp <= i_temperature;
            r_lo   <= '0;
            r_hi   <= T_ONE;
            r_mid  <= MID_INIT;
        end else if (i_cmd.decide) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_mid <= mid_sum[MID_W:1];
        end

        if (i_cmd.load_out) begin
            r_fan_speed <= r_acc_y[FRAC_SHIFT +: COORD_W];
        end
    end

    assign o_fan_speed = r_fan_speed;

endmodule

### hw/rtl/bezier_fan_curve_bisection_top.sv
// Fan curve lookup: temperature in, fan speed out, read from a cubic Bezier
// curve with four control points held in configuration registers.
// Input channel: i_in_valid / o_in_stall with i_temperature (unsigned 8.8).
// Output channel: o_out_valid / i_out_stall with o_fan_speed (unsigned 7.8).
// Config channel: i_cfg_valid / o_cfg_ready (always high), i_cfg_index 0..7
// selects p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y; other indexes are
// ignored and bit 15 of the data is dropped. Write only while idle.
// One request is worked on at a time. Each bisection step issues 14 products
// back to back on a single 49x17 multiplier, then a compare in S_DECIDE.
// The search runs up to T_BITS steps and stops early on an exact x match.
// The result is registered in S_FINISH; the next request is taken after
// that, in S_IDLE.
// While a result waits under i_out_stall, a new request is still taken and
// worked on; it holds in its last cycle until the output register frees.
// Reset (synchronous, active low) loads the default curve and empties the
// output register.
module bezier_fan_curve_bisection_top
    import bfcb_pkg::*;
#(
    parameter int T_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [TEMP_W-1:0]     i_temperature,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_W-1:0]    o_fan_speed,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    bfcb_ctrl #(
        .T_BITS (T_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    bfcb_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_write   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_temperature (i_temperature),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .o_fan_speed   (o_fan_speed)
    );

`ifndef SYNTHESIS
    // a taken request blocks the input until its search is done
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a search is running");

    // a result is never written over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.load_out |-> (!o_out_valid || !i_out_stall))
        else $error("pending result overwritten");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.load_out |=> o_out_valid)
        else $error("loaded result not presented");

    // the interval only narrows while no multiply is issued and no search starts
    a_decide_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.decide |-> (dp_cmd.op == OP_NONE && !dp_cmd.start))
        else $error("compare overlaps curve evaluation");
`endif

endmodule

### verif/tb_bezier_fan_curve_bisection_top.sv
`timescale 1ns / 1ps

module tb_bezier_fan_curve_bisection_top;
    import bfcb_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int T_STEPS        = 16;
    localparam int SETTLE_CYCLES  = 15 * T_STEPS + 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 6;
    localparam int PHASE_REQS     = 105;
    localparam int HOLD_CYCLES    = 700;
    localparam int MAX_REPORTS    = 20;
    localparam logic [COORD_W-1:0] COORD_TOP = 15'd25600;
    localparam logic [COORD_W-1:0] COORD_MAX = 15'h7FFF;

    // indexes past the register list, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 4'd8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 4'd15;

    typedef enum logic {ROW_CFG, ROW_REQ} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [TEMP_W-1:0]     temp;
        bit                    typed;
        logic [COORD_W-1:0]    speed;
    } t_stim_row;

    typedef enum int {
        CURVE_DEFAULT, CURVE_SPREAD, CURVE_RISING, CURVE_WIDE, CURVE_EDGES
    } t_curve_kind;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_stall;
    logic [TEMP_W-1:0]     i_temperature = '0;
    logic                  o_out_valid;
    logic                  i_out_stall   = 1'b0;
    logic [COORD_W-1:0]    o_fan_speed;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    logic [COORD_W-1:0] curve_reg [NUM_REGS];
    logic [COORD_W-1:0] speed_q [$];
    logic [COORD_W-1:0] want_speed;
    t_stim_row          dir_rows [$];

    int unsigned err_cnt      = 0;
    int unsigned n_temps      = 0;
    int unsigned n_speeds     = 0;
    int unsigned n_writes     = 0;
    int unsigned n_settings   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_len     = 0;
    bit          hold_req     = 1'b0;
    bit          tx_idle_on   = 1'b1;
    bit          rx_idle_on   = 1'b1;

    bezier_fan_curve_bisection_top #(
        .T_BITS(T_STEPS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_temperature (i_temperature),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_fan_speed   (o_fan_speed),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // exact curve point: Bernstein weights sum to 2^48, so >> 48 is the blend
    function automatic void bezier_point(input logic [31:0] t,
                                         output logic [TEMP_W-1:0] px,
                                         output logic [COORD_W-1:0] py);
        logic [63:0] tq, uq, w0, w1, w2, w3, sx, sy;
        tq = 64'(t);
        uq = 64'(T_ONE) - tq;
        w0 = uq * uq * uq;
        w1 = 64'd3 * uq * uq * tq;
        w2 = 64'd3 * uq * tq * tq;
        w3 = tq * tq * tq;
        sx = w0 * 64'(curve_reg[REG_P0_X]) + w1 * 64'(curve_reg[REG_P1_X])
           + w2 * 64'(curve_reg[REG_P2_X]) + w3 * 64'(curve_reg[REG_P3_X]);
        sy = w0 * 64'(curve_reg[REG_P0_Y]) + w1 * 64'(curve_reg[REG_P1_Y])
           + w2 * 64'(curve_reg[REG_P2_Y]) + w3 * 64'(curve_reg[REG_P3_Y]);
        px = TEMP_W'(sx >> FRAC_SHIFT);
        py = COORD_W'(sy >> FRAC_SHIFT);
    endfunction

    function automatic logic [COORD_W-1:0] predict_fan_speed(input logic [TEMP_W-1:0] temp);
        logic [31:0]        lo, hi, mid;
        logic [TEMP_W-1:0]  px;
        logic [COORD_W-1:0] py;
        lo = '0;
        hi = 32'(T_ONE);
        py = '0;
        for (int s = 0; s < T_STEPS; s++) begin
            mid = (lo + hi) >> 1;
            bezier_point(mid, px, py);
            if (px == temp)
                break;
            if (px < temp)
                lo = mid;
            else
                hi = mid;
        end
        return py;
    endfunction

    function automatic t_stim_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        t_stim_row r;
        r = '{ROW_CFG, idx, data, '0, 1'b0, '0};
        return r;
    endfunction

    function automatic t_stim_row req_row(input logic [TEMP_W-1:0] temp,
                                          input bit typed = 1'b0,
                                          input logic [COORD_W-1:0] speed = '0);
        t_stim_row r;
        r = '{ROW_REQ, '0, '0, temp, typed, speed};
        return r;
    endfunction

    function automatic void queue_row(input t_stim_row row);
        dir_rows = {dir_rows, row};
    endfunction

    // keeps i_cfg_valid high so writes can follow back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < NUM_REGS)
            curve_reg[idx[REG_IDX_W-1:0]] = data[COORD_W-1:0];
        n_writes++;
    endtask

    // leaves valid high; the next call or finish_requests decides what follows
    task automatic send_temp(input logic [TEMP_W-1:0] temp, input bit typed,
                             input logic [COORD_W-1:0] speed);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_temperature <= temp;
        do @(posedge i_clk); while (o_in_stall);
        speed_q = {speed_q, typed ? speed : predict_fan_speed(temp)};
        n_temps++;
    endtask

    task automatic finish_requests();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (speed_q.size() != 0);
    endtask

    task automatic load_curve(input t_curve_kind kind);
        logic [COORD_W-1:0]    coord;
        logic [CFG_DATA_W-1:0] data;
        int unsigned           xs [$];
        for (int k = 0; k < 4; k++)
            xs = {xs, $urandom_range(0, COORD_TOP)};
        xs.sort();
        for (int r = 0; r < NUM_REGS; r++) begin
            case (kind)
                CURVE_DEFAULT: coord = REG_RESET[r];
                CURVE_SPREAD:  coord = COORD_W'($urandom_range(0, COORD_TOP));
                CURVE_RISING:  coord = (r % 2 == 0) ? COORD_W'(xs[r / 2])
                                                    : COORD_W'($urandom_range(0, COORD_TOP));
                CURVE_WIDE:    coord = COORD_W'($urandom_range(0, COORD_MAX));
                default: begin
                    case ($urandom_range(0, 2))
                        0:       coord = '0;
                        1:       coord = COORD_TOP;
                        default: coord = COORD_MAX;
                    endcase
                end
            endcase
            // bit 15 is don't-care on the bus, toggle it anyway
            data = {1'($urandom_range(0, 1)), coord};
            write_reg(CFG_IDX_W'(r), data);
        end
        write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_SPARE_LO, CFG_IDX_SPARE_HI)),
                  CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_speeds++;
            if (speed_q.size() == 0) begin
                flag_error($sformatf("fan speed %0d with no request pending", o_fan_speed));
            end else begin
                want_speed = speed_q.pop_front();
                if (o_fan_speed !== want_speed)
                    flag_error($sformatf("fan_speed got %0d, want %0d",
                                         o_fan_speed, want_speed));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: nothing moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, speed_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // output side back-pressure
    initial begin : rx_side
        int unsigned n;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
            end
            n = rx_idle_on ? $urandom_range(0, 9) : 0;
            if (n != 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    initial begin : stim
        bit                 prev_cfg;
        logic [TEMP_W-1:0]  temp, px, xmin, xmax;
        logic [COORD_W-1:0] py;

        curve_reg = REG_RESET;

        // defaults after reset, then dropped writes past the list
        queue_row(req_row(16'h0000));
        queue_row(req_row(16'hFFFF));
        queue_row(req_row(16'd12800));
        queue_row(req_row(16'd25600));
        queue_row(req_row(16'd25601));
        queue_row(cfg_row(CFG_IDX_SPARE_LO, 16'h1234));
        queue_row(cfg_row(CFG_IDX_SPARE_HI, 16'hFFFF));
        queue_row(req_row(16'd12800));
        // straight x, flat y at full scale (bit 15 dropped)
        queue_row(cfg_row(REG_P0_X, 16'd0));
        queue_row(cfg_row(REG_P1_X, 16'd8192));
        queue_row(cfg_row(REG_P2_X, 16'd16384));
        queue_row(cfg_row(REG_P3_X, 16'd24576));
        queue_row(cfg_row(REG_P0_Y, 16'hFFFF));
        queue_row(cfg_row(REG_P1_Y, 16'hFFFF));
        queue_row(cfg_row(REG_P2_Y, 16'hFFFF));
        queue_row(cfg_row(REG_P3_Y, 16'hFFFF));
        queue_row(req_row(16'h0000, 1'b1, 15'd32767));
        queue_row(req_row(16'hFFFF, 1'b1, 15'd32767));
        queue_row(req_row(16'd12288, 1'b1, 15'd32767));
        // y = x line: exact hits on the first and second step
        queue_row(cfg_row(REG_P0_Y, 16'd0));
        queue_row(cfg_row(REG_P1_Y, 16'd8192));
        queue_row(cfg_row(REG_P2_Y, 16'd16384));
        queue_row(cfg_row(REG_P3_Y, 16'd24576));
        queue_row(req_row(16'd12288, 1'b1, 15'd12288));
        queue_row(req_row(16'd6144, 1'b1, 15'd6144));
        queue_row(req_row(16'd18432, 1'b1, 15'd18432));
        queue_row(req_row(16'h0000));
        queue_row(req_row(16'hFFFF));
        queue_row(req_row(16'd24576));
        // collapsed curve at zero
        queue_row(cfg_row(REG_P0_X, 16'd0));
        queue_row(cfg_row(REG_P1_X, 16'd0));
        queue_row(cfg_row(REG_P2_X, 16'd0));
        queue_row(cfg_row(REG_P3_X, 16'd0));
        queue_row(cfg_row(REG_P0_Y, 16'h8000));
        queue_row(cfg_row(REG_P1_Y, 16'h8000));
        queue_row(cfg_row(REG_P2_Y, 16'h8000));
        queue_row(cfg_row(REG_P3_Y, 16'h8000));
        queue_row(req_row(16'h0000, 1'b1, 15'd0));
        queue_row(req_row(16'hFFFF, 1'b1, 15'd0));
        // out-of-range points at the top code
        queue_row(cfg_row(REG_P0_X, 16'h7FFF));
        queue_row(cfg_row(REG_P1_X, 16'h7FFF));
        queue_row(cfg_row(REG_P2_X, 16'h7FFF));
        queue_row(cfg_row(REG_P3_X, 16'h7FFF));
        queue_row(cfg_row(REG_P1_Y, 16'h7FFF));
        queue_row(cfg_row(REG_P2_Y, 16'd0));
        queue_row(cfg_row(REG_P3_Y, 16'h7FFF));
        queue_row(req_row(16'd32767));
        queue_row(req_row(16'd32766));
        queue_row(req_row(16'hFFFF));
        queue_row(req_row(16'h0000));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        prev_cfg = 1'b0;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                if (!prev_cfg)
                    finish_requests();
                write_reg(dir_rows[r].idx, dir_rows[r].data);
                prev_cfg = 1'b1;
            end else begin
                if (prev_cfg)
                    i_cfg_valid <= 1'b0;
                send_temp(dir_rows[r].temp, dir_rows[r].typed, dir_rows[r].speed);
                prev_cfg = 1'b0;
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            finish_requests();
            load_curve(t_curve_kind'(ph % 5));
            xmin = curve_reg[REG_P0_X];
            xmax = xmin;
            for (int r = 0; r < NUM_REGS; r += 2) begin
                if (curve_reg[r] < xmin) xmin = curve_reg[r];
                if (curve_reg[r] > xmax) xmax = curve_reg[r];
            end
            for (int k = 0; k < PHASE_REQS; k++) begin
                if (k % 25 == 0) begin
                    tx_idle_on = ($urandom_range(0, 3) != 0);
                    rx_idle_on = ($urandom_range(0, 3) != 0);
                end
                // long output hold with the input side pushing flat out
                if (ph == 2 && k == 5) begin
                    hold_len   = HOLD_CYCLES;
                    hold_req   = 1'b1;
                    tx_idle_on = 1'b0;
                end
                case ($urandom_range(0, 9))
                    0:       temp = TEMP_W'($urandom);
                    1, 2:    temp = TEMP_W'($urandom_range(xmax, xmin));
                    3, 4, 5: begin
                        // a temperature the curve hits exactly somewhere
                        bezier_point($urandom_range(1, 65535), px, py);
                        temp = px;
                    end
                    6: begin
                        case ($urandom_range(0, 3))
                            0:       temp = '0;
                            1:       temp = '1;
                            2:       temp = xmin;
                            default: temp = xmax;
                        endcase
                    end
                    default: temp = TEMP_W'($urandom_range(0, COORD_TOP));
                endcase
                send_temp(temp, 1'b0, '0);
            end
        end

        finish_requests();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d temperature requests and %0d fan speed results",
                 n_temps, n_speeds);
        $display("over %0d register writes and %0d random curves; %0d mismatches",
                 n_writes, n_settings, err_cnt);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
hw/rtl/bfcb_pkg.sv
hw/rtl/bfcb_ctrl.sv
hw/rtl/bfcb_datapath.sv
hw/rtl/bezier_fan_curve_bisection_top.sv
verif/tb_bezier_fan_curve_bisection_top.sv
